[hdl/bitmap_page_allocator_macros.svh]
// assertion macros for the bitmap page allocator
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap page allocator check failed");

// next-cycle implication, checked outside reset
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap page allocator check failed");

`endif

[hdl/bpa_pkg.sv]
// shared types and constants of the bitmap page allocator
package bpa_pkg;

	localparam int PAGE_W   = 20;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int SIZE_W   = 11;
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;

	localparam logic [PAGE_W:0] PAGE_SPACE = 21'h100000;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOMEM = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 11'd1024;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} bpa_hit_t;

	// bits below k set
	function automatic logic [WORD_W-1:0] lo_mask(input logic [BIT_W-1:0] k);
		logic [WORD_W:0] t;
		t = ({{WORD_W{1'b0}}, 1'b1} << k) - {{WORD_W{1'b0}}, 1'b1};
		return t[WORD_W-1:0];
	endfunction

endpackage

[hdl/bpa_channels.sv]
// request and response channel interfaces
interface bpa_req_if;
	import bpa_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [PAGE_W-1:0] page;
	modport source (output valid, cmd, page, input ready);
	modport sink (input valid, cmd, page, output ready);
endinterface

interface bpa_rsp_if;
	import bpa_pkg::*;
	logic                valid;
	logic                ready;
	logic [PAGE_W-1:0]   page_res;
	logic [STATUS_W-1:0] status;
	modport source (output valid, page_res, status, input ready);
	modport sink (input valid, page_res, status, output ready);
endinterface

[hdl/bpa_bitmap_ram.sv]
// used-bit bitmap memory, one write and one registered read port
module bpa_bitmap_ram #(
	parameter int WORDS = 32,
	parameter int WAW   = 5
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [WAW-1:0]            waddr,
	input  logic [bpa_pkg::WORD_W-1:0] wdata,
	input  logic                      re,
	input  logic [WAW-1:0]            raddr,
	output logic [bpa_pkg::WORD_W-1:0] rdata
);
	import bpa_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/bpa_word_scan.sv]
// masks one bitmap word to the live scan window and finds its lowest free page
module bpa_word_scan #(
	parameter int WAW = 5,
	parameter int CW  = 11
) (
	input  logic [WAW-1:0]             addr,
	input  logic                       wrap,
	input  logic [CW-1:0]              off,
	input  logic [CW-1:0]              n,
	input  logic [bpa_pkg::WORD_W-1:0] data,
	output bpa_pkg::bpa_hit_t          hit
);
	import bpa_pkg::*;

	logic [WAW:0]      addr_x;
	logic [WAW:0]      n_word;
	logic [WAW:0]      off_word;
	logic [WORD_W-1:0] m_n;
	logic [WORD_W-1:0] m_off;
	logic [WORD_W-1:0] free_w;

	assign addr_x   = (WAW+1)'(addr);
	assign n_word   = n[CW-1:BIT_W];
	assign off_word = off[CW-1:BIT_W];

	// pages below the pool end
	always_comb begin
		if (addr_x < n_word) begin
			m_n = '1;
		end else if (addr_x == n_word) begin
			m_n = lo_mask(n[BIT_W-1:0]);
		end else begin
			m_n = '0;
		end
	end

	// first lap from the offset up, second lap up to the offset
	always_comb begin
		if (!wrap) begin
			if (addr_x > off_word) begin
				m_off = '1;
			end else if (addr_x == off_word) begin
				m_off = ~lo_mask(off[BIT_W-1:0]);
			end else begin
				m_off = '0;
			end
		end else begin
			if (addr_x < off_word) begin
				m_off = '1;
			end else if (addr_x == off_word) begin
				m_off = lo_mask(off[BIT_W-1:0]);
			end else begin
				m_off = '0;
			end
		end
	end

	assign free_w = ~data & m_n & m_off;

	always_comb begin
		hit.found = |free_w;
		hit.idx   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_w[i]) begin
				hit.idx = BIT_W'(i);
			end
		end
	end

endmodule

[hdl/bitmap_page_allocator.sv]
// next-fit bitmap page allocator top level
// One used bit per pool page is held in a bitmap memory of 32-page words with a
// single registered read port; items are handled one at a time. An allocate
// reads one bitmap word per cycle from the word holding the rotating offset,
// wrapping at the pool end, until it finds a free page or a full lap finds the
// pool full. A free or mark is a read-modify-write of one word; a free or mark
// of a page outside the pool skips the write, and an unused command or an
// allocate on an empty pool goes straight to the result. The result sits in an
// output register, so the next item is taken while it waits. After reset the
// block clears the bitmap, one word per cycle, before taking its first item;
// configuration writes are taken throughout. pool_base_page lies at byte
// address 0 and pool_size at 4; the pool is cut to POOL_PAGES pages and to the
// end of the 20-bit page space.
`include "bitmap_page_allocator_macros.svh"

module bitmap_page_allocator #(
	parameter int POOL_PAGES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	bpa_req_if.sink                    req,
	bpa_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import bpa_pkg::*;

	// bitmap geometry
	localparam int WORDS = (POOL_PAGES + WORD_W - 1) / WORD_W;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	// wide enough for any page offset and for the pool size itself
	localparam int CW    = WAW + BIT_W + 1;
	localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_SCAN   = 6'b000100,
		S_RMW_RD = 6'b001000,
		S_RMW_WR = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t              state_q;
	logic [WAW-1:0]      clr_q;

	// configuration
	logic [PAGE_W-1:0]   base_q;
	logic [SIZE_W-1:0]   size_q;
	logic                cfg_wr;

	// allocator state kept outside the bitmap
	logic [CW-1:0]       next_off_q;

	// per-item context
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       off_q;
	logic [PAGE_W-1:0]   page_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [BIT_W-1:0]    bit_q;

	// scan read pipeline
	logic [WAW-1:0]      cur_q;
	logic                wrap_q;
	logic                v_s1;
	logic [WAW-1:0]      addr_s1;
	logic                wrap_s1;

	// pending and output results
	logic [PAGE_W-1:0]   pres_q;
	logic [STATUS_W-1:0] pst_q;
	logic                out_v_q;
	logic [PAGE_W-1:0]   out_page_q;
	logic [STATUS_W-1:0] out_st_q;

	// bitmap port
	logic                mem_we;
	logic [WAW-1:0]      mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [WAW-1:0]      mem_raddr;
	logic [WORD_W-1:0]   mem_rdata;

	// derived values
	logic [PAGE_W:0]     room_c;
	logic [PAGE_W:0]     len_c;
	logic [CW-1:0]       n_c;
	logic [CW-1:0]       start_c;
	logic [CW-1:0]       n_m1;
	logic [WAW-1:0]      last_w;
	logic                last_s1;
	logic [PAGE_W:0]     diff_c;
	logic                in_rng;
	logic [CW-1:0]       idx_c;
	logic [CW-1:0]       found_off;
	logic [CW-1:0]       found_nx;
	logic [CW-1:0]       next_off_c;
	logic [PAGE_W-1:0]   found_page;
	logic                accept;
	logic                load_out;
	bpa_hit_t            hit;

	// effective pool length: smallest of register, capacity and page space room
	always_comb begin
		room_c = PAGE_SPACE - {1'b0, base_q};
		len_c  = (PAGE_W+1)'(size_q);
		if (len_c > (PAGE_W+1)'(POOL_PAGES)) begin
			len_c = (PAGE_W+1)'(POOL_PAGES);
		end
		if (len_c > room_c) begin
			len_c = room_c;
		end
	end

	assign n_c     = CW'(len_c);
	// an offset left beyond a shrunk pool restarts at the pool start
	assign start_c = (next_off_q < n_c) ? next_off_q : '0;

	assign n_m1    = n_q - CW'(1);
	assign last_w  = n_m1[WAW+BIT_W-1:BIT_W];
	// second lap back at the starting word closes the lap
	assign last_s1 = wrap_s1 && ((WAW+1)'(addr_s1) == off_q[CW-1:BIT_W]);

	// free and mark range check relative to the pool base
	assign diff_c  = {1'b0, page_q} - {1'b0, base_q};
	assign in_rng  = !diff_c[PAGE_W] && (diff_c[PAGE_W-1:0] < PAGE_W'(n_q));
	assign idx_c   = diff_c[CW-1:0];

	assign found_off  = CW'({addr_s1, hit.idx});
	assign found_nx   = found_off + CW'(1);
	assign next_off_c = (found_nx >= n_q) ? '0 : found_nx;
	assign found_page = base_q + PAGE_W'(found_off);

	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == S_DONE) && (!out_v_q || rsp.ready);

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = out_v_q;
	assign rsp.page_res = out_page_q;
	assign rsp.status   = out_st_q;

	// apb register port, index taken from the word address bit
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? 32'(size_q) : 32'(base_q);

	bpa_word_scan #(
		.WAW (WAW),
		.CW  (CW)
	) u_scan (
		.addr (addr_s1),
		.wrap (wrap_s1),
		.off  (off_q),
		.n    (n_q),
		.data (mem_rdata),
		.hit  (hit)
	);

	bpa_bitmap_ram #(
		.WORDS (WORDS),
		.WAW   (WAW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// bitmap access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = cur_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_SCAN: begin
				mem_re = 1'b1;
				// claim the first free page of the word
				if (v_s1 && hit.found) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata | (WORD_W'(1) << hit.idx);
				end
			end
			S_RMW_RD: begin
				mem_re    = in_rng;
				mem_raddr = idx_c[WAW+BIT_W-1:BIT_W];
			end
			S_RMW_WR: begin
				mem_we = 1'b1;
				if (cmd_q == CMD_MARK) begin
					mem_wdata = mem_rdata | (WORD_W'(1) << bit_q);
				end else begin
					mem_wdata = mem_rdata & ~(WORD_W'(1) << bit_q);
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			base_q     <= '0;
			size_q     <= POOL_SIZE_RST;
			next_off_q <= '0;
			cur_q      <= '0;
			wrap_q     <= 1'b0;
			v_s1       <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2]) begin
					size_q <= pwdata[SIZE_W-1:0];
				end else begin
					base_q <= pwdata[PAGE_W-1:0];
				end
			end
			// a result taken this cycle is replaced only by a new one
			if (rsp.ready && out_v_q && !load_out) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WAW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_ALLOC) begin
							if (n_c == '0) begin
								state_q <= S_DONE;
							end else begin
								cur_q   <= start_c[WAW+BIT_W-1:BIT_W];
								wrap_q  <= 1'b0;
								v_s1    <= 1'b0;
								state_q <= S_SCAN;
							end
						end else if (req.cmd == CMD_FREE || req.cmd == CMD_MARK) begin
							state_q <= S_RMW_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					// one word read per cycle, evaluated the cycle after
					if (cur_q == last_w) begin
						cur_q  <= '0;
						wrap_q <= 1'b1;
					end else begin
						cur_q <= cur_q + WAW'(1);
					end
					if (v_s1 && hit.found) begin
						next_off_q <= next_off_c;
						v_s1       <= 1'b0;
						state_q    <= S_DONE;
					end else if (v_s1 && last_s1) begin
						v_s1    <= 1'b0;
						state_q <= S_DONE;
					end else begin
						v_s1 <= 1'b1;
					end
				end
				S_RMW_RD: begin
					if (in_rng) begin
						state_q <= S_RMW_WR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RMW_WR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item context and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q    <= n_c;
				off_q  <= start_c;
				page_q <= req.page;
				cmd_q  <= req.cmd;
				pres_q <= '0;
				if (req.cmd == CMD_ALLOC) begin
					pst_q <= STATUS_NOMEM;
				end else begin
					pst_q <= STATUS_OK;
				end
			end
			S_SCAN: begin
				addr_s1 <= cur_q;
				wrap_s1 <= wrap_q;
				if (v_s1 && hit.found) begin
					pres_q <= found_page;
					pst_q  <= STATUS_OK;
				end
			end
			S_RMW_RD: begin
				addr_s1 <= idx_c[WAW+BIT_W-1:BIT_W];
				bit_q   <= idx_c[BIT_W-1:0];
				if (!in_rng) begin
					pst_q <= STATUS_RANGE;
				end
			end
			S_DONE: begin
				if (load_out) begin
					out_page_q <= pres_q;
					out_st_q   <= pst_q;
				end
			end
			default: begin
				pres_q <= pres_q;
			end
		endcase
	end

	// an accepted item holds off the next one
	`BPA_ASSERT_NEXT(a_one_item, clk, arst_n, accept, !req.ready)
	// a new result appears only from the result hand-off state
	`BPA_ASSERT_NOW(a_rsp_src, clk, arst_n, $rose(out_v_q), $past(state_q) == S_DONE)
	// the clearing pass sweeps every word before the first item
	`BPA_ASSERT_NEXT(a_clear_len, clk, arst_n,
		state_q == S_CLEAR && clr_q != LAST_WORD, state_q == S_CLEAR)
	// the stored offset always lies inside the bitmap
	`BPA_ASSERT_NOW(a_off_bound, clk, arst_n, 1'b1, next_off_q < CW'(POOL_PAGES))

endmodule
